### hdl/cdml_pkg.sv
// Package for the CD MSF/LBA address converter.
// Holds the beat structs, the operation codes and the disc geometry constants.
// Depends on nothing.
`default_nettype none

package cdml_pkg;

  localparam logic OP_MSF_TO_LBA = 1'b0;
  localparam logic OP_LBA_TO_MSF = 1'b1;

  localparam int unsigned FRAMES_PER_SEC = 75;
  localparam int unsigned SECS_PER_MIN   = 60;
  localparam int unsigned MINUTE_LIMIT   = 100;
  localparam int unsigned LEADIN_MINUTE  = 90;
  localparam int unsigned PREGAP_FRAMES  = 2 * FRAMES_PER_SEC;
  localparam int unsigned FULL_SPAN      = MINUTE_LIMIT * SECS_PER_MIN * FRAMES_PER_SEC;

  // Reciprocals for division by 75 (input below 2^20) and by 60 (input below 2^13).
  localparam int unsigned DIV75_SHIFT = 26;
  localparam int unsigned DIV75_MUL   = (2 ** DIV75_SHIFT) / FRAMES_PER_SEC + 1;
  localparam int unsigned DIV60_SHIFT = 19;
  localparam int unsigned DIV60_MUL   = (2 ** DIV60_SHIFT) / SECS_PER_MIN + 1;

  typedef struct packed {
    logic              op;
    logic              bcd;
    logic [7:0]        minute_in;
    logic [7:0]        second_in;
    logic [7:0]        frame_in;
    logic signed [19:0] lba_in;
  } cmd_t;

  typedef struct packed {
    logic signed [20:0] lba_out;
    logic [7:0]         minute_out;
    logic [6:0]         second_out;
    logic [6:0]         frame_out;
    logic               addr_valid;
  } result_t;

endpackage

`default_nettype wire

### hdl/cd_msf_lba_converter.sv
// Top level of the CD MSF/LBA address converter, a six-stage pipeline.
// Depends on cdml_pkg for the beat structs, operation codes and constants.
//
// A command beat is taken in every cycle in which start is high and busy is low;
// busy is high only during reset. Each command yields one result beat, marked by
// done, and the results leave in command order. The receiver cannot stall: each
// result is on the ports for one cycle only. The two reciprocal multiplications
// that split the address into frames, seconds and minutes are each followed by
// their own register stage.
`default_nettype none

module cd_msf_lba_converter
  import cdml_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire cmd_t    cmd,
  output logic         done,
  output result_t      result
);

  function automatic logic [7:0] digits_to_bin(input logic [7:0] v);
    return 8'(v[7:4] * 8'd10) + 8'(v[3:0]);
  endfunction

  function automatic logic [7:0] bin_to_digits(input logic [7:0] v);
    logic [17:0] prod;
    logic [7:0]  tens;
    logic [7:0]  units;
    prod  = 18'(v) * 18'd205;
    tens  = 8'(prod[17:11]);
    units = v - 8'(tens * 8'd10);
    return 8'({tens, 4'b0000} + units);
  endfunction

  localparam logic signed [21:0] NEG_SPAN = -22'(FULL_SPAN);

  logic v1, v2, v3, v4, v5;

  // Stage 1: field decode and pregap shift.
  logic               op1, bcd1;
  logic [7:0]         m1, s1, f1;
  logic signed [21:0] sh1;
  // Stage 2: minute-second sum, checks and lead-in wrap.
  logic               op2, bcd2, ok2, lead2;
  logic [7:0]         f2;
  logic [13:0]        ms2;
  logic [19:0]        u2;
  // Stage 3: MSF to LBA result and frame quotient product.
  logic               op3, bcd3, ok3;
  logic [20:0]        lba3;
  logic [19:0]        u3;
  logic [39:0]        prod3;
  // Stage 4: frame remainder and minute quotient product.
  logic               op4, bcd4, ok4;
  logic [20:0]        lba4;
  logic [12:0]        q4;
  logic [6:0]         f4;
  logic [26:0]        prod4;
  // Stage 5: minute and second.
  logic               op5, bcd5, ok5;
  logic [20:0]        lba5;
  logic [7:0]         m5;
  logic [5:0]         s5;
  logic [6:0]         f5;

  logic [12:0]        q3_w;
  logic [7:0]         m4_w;
  logic [7:0]         min_w, sec_w, frm_w;
  result_t            result_next;

  assign busy = rst;
  assign q3_w = prod3[38:26];
  assign m4_w = prod4[26:19];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= start && !busy;
      v2   <= v1;
      v3   <= v2;
      v4   <= v3;
      v5   <= v4;
      done <= v5;
    end
  end

  always_ff @(posedge clk) begin
    op1  <= cmd.op;
    bcd1 <= cmd.bcd;
    m1   <= cmd.bcd ? digits_to_bin(cmd.minute_in) : cmd.minute_in;
    s1   <= cmd.bcd ? digits_to_bin(cmd.second_in) : cmd.second_in;
    f1   <= cmd.bcd ? digits_to_bin(cmd.frame_in)  : cmd.frame_in;
    sh1  <= 22'({{2{cmd.lba_in[19]}}, cmd.lba_in}) + 22'(PREGAP_FRAMES);

    op2   <= op1;
    bcd2  <= bcd1;
    f2    <= f1;
    ms2   <= 14'(m1) * 14'(SECS_PER_MIN) + 14'(s1);
    ok2   <= (m1 < 8'(MINUTE_LIMIT)) && (s1 < 8'(SECS_PER_MIN)) &&
             (f1 < 8'(FRAMES_PER_SEC));
    lead2 <= m1 >= 8'(LEADIN_MINUTE);
    if (sh1 < NEG_SPAN) begin
      u2 <= 20'(sh1 + 22'(2 * FULL_SPAN));
    end else if (sh1 < 0) begin
      u2 <= 20'(sh1 + 22'(FULL_SPAN));
    end else begin
      u2 <= 20'(sh1);
    end

    op3   <= op2;
    bcd3  <= bcd2;
    ok3   <= ok2;
    lba3  <= 21'(22'(ms2) * 22'(FRAMES_PER_SEC) + 22'(f2) - 22'(PREGAP_FRAMES)
                 - (lead2 ? 22'(FULL_SPAN) : 22'd0));
    u3    <= u2;
    prod3 <= 40'(u2) * 40'(DIV75_MUL);

    op4   <= op3;
    bcd4  <= bcd3;
    ok4   <= ok3;
    lba4  <= lba3;
    q4    <= q3_w;
    f4    <= 7'(u3 - 20'(20'(q3_w) * 20'(FRAMES_PER_SEC)));
    prod4 <= 27'(q3_w) * 27'(DIV60_MUL);

    op5   <= op4;
    bcd5  <= bcd4;
    ok5   <= ok4;
    lba5  <= lba4;
    m5    <= m4_w;
    s5    <= 6'(q4 - 13'(13'(m4_w) * 13'(SECS_PER_MIN)));
    f5    <= f4;

    result <= result_next;
  end

  always_comb begin
    min_w = bcd5 ? bin_to_digits(m5) : m5;
    sec_w = bcd5 ? bin_to_digits(8'(s5)) : 8'(s5);
    frm_w = bcd5 ? bin_to_digits(8'(f5)) : 8'(f5);
    result_next = '0;
    if (op5 == OP_MSF_TO_LBA) begin
      result_next.lba_out    = $signed(lba5);
      result_next.addr_valid = ok5;
    end else begin
      result_next.minute_out = min_w;
      result_next.second_out = sec_w[6:0];
      result_next.frame_out  = frm_w[6:0];
      result_next.addr_valid = 1'b1;
    end
  end

  logic op6, bcd6;

  always_ff @(posedge clk) begin
    op6  <= op5;
    bcd6 <= bcd5;
  end

`ifndef NO_ASSERTIONS
  a_forms_exclusive: assert property (@(posedge clk) disable iff (rst)
    done && result.lba_out != 0 |->
      result.minute_out == 0 && result.second_out == 0 && result.frame_out == 0)
    else $error("result carries both an LBA and an MSF address");

  a_lba_op_valid: assert property (@(posedge clk) disable iff (rst)
    done && op6 == OP_LBA_TO_MSF |-> result.addr_valid && result.lba_out == 0)
    else $error("LBA to MSF result has a stray LBA or a cleared valid flag");

  a_binary_range: assert property (@(posedge clk) disable iff (rst)
    done && op6 == OP_LBA_TO_MSF && !bcd6 |->
      result.frame_out < 7'(FRAMES_PER_SEC) && result.second_out < 7'(SECS_PER_MIN))
    else $error("binary MSF result out of range");
`endif

endmodule

`default_nettype wire

### verif/tb_cd_msf_lba_converter.sv
`timescale 1ns / 100ps
// Testbench for the CD MSF/LBA address converter, checked beat by beat against a predictor.
// Depends on cdml_pkg for the command and result structs, the operation codes and constants.

module tb_cd_msf_lba_converter;
  import cdml_pkg::*;

  class AddressScoreboard;
    result_t expected_results[$];
    int mismatches = 0;

    function int unsigned decode_bcd(logic [7:0] b);
      return int'(b[7:4]) * 10 + int'(b[3:0]);
    endfunction

    function int unsigned encode_bcd(int unsigned v);
      return (((v / 10) << 4) + (v % 10)) & 32'hFF;
    endfunction

    function result_t convert_address(cmd_t c);
      result_t r;
      int unsigned m, s, f;
      int addr;
      r = '0;
      if (c.op == OP_MSF_TO_LBA) begin
        m = 32'(c.minute_in);
        s = 32'(c.second_in);
        f = 32'(c.frame_in);
        if (c.bcd) begin
          m = decode_bcd(c.minute_in);
          s = decode_bcd(c.second_in);
          f = decode_bcd(c.frame_in);
        end
        addr = int'(FRAMES_PER_SEC * (SECS_PER_MIN * m + s) + f) - int'(PREGAP_FRAMES);
        if (m >= LEADIN_MINUTE) addr -= int'(FULL_SPAN);
        r.lba_out = addr[20:0];
        r.addr_valid = (m < MINUTE_LIMIT) && (s < SECS_PER_MIN) && (f < FRAMES_PER_SEC);
      end else begin
        addr = int'(c.lba_in) + int'(PREGAP_FRAMES);
        if (addr < 0) addr += int'(FULL_SPAN);
        if (addr < 0) addr += int'(FULL_SPAN);
        f = addr % FRAMES_PER_SEC;
        s = (addr / FRAMES_PER_SEC) % SECS_PER_MIN;
        m = (addr / (FRAMES_PER_SEC * SECS_PER_MIN)) & 32'hFF;
        if (c.bcd) begin
          m = encode_bcd(m);
          s = encode_bcd(s);
          f = encode_bcd(f);
        end
        r.minute_out = m[7:0];
        r.second_out = s[6:0];
        r.frame_out = f[6:0];
        r.addr_valid = 1'b1;
      end
      return r;
    endfunction

    function void flag(string what, int want, int got);
      mismatches++;
      if (mismatches <= 10) $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    endfunction

    function void note_command(cmd_t c);
      expected_results.push_back(convert_address(c));
    endfunction

    function void check_result(result_t r);
      result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result beat with nothing expected: %h", r);
        return;
      end
      want = expected_results.pop_front();
      if (r.lba_out !== want.lba_out) flag("lba_out", int'(want.lba_out), int'(r.lba_out));
      if (r.minute_out !== want.minute_out)
        flag("minute_out", int'(want.minute_out), int'(r.minute_out));
      if (r.second_out !== want.second_out)
        flag("second_out", int'(want.second_out), int'(r.second_out));
      if (r.frame_out !== want.frame_out)
        flag("frame_out", int'(want.frame_out), int'(r.frame_out));
      if (r.addr_valid !== want.addr_valid)
        flag("addr_valid", int'(want.addr_valid), int'(r.addr_valid));
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction

    function void final_check();
      if (expected_results.size() != 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0d result beats never arrived", expected_results.size());
      end
    endfunction
  endclass

  localparam int RANDOM_ITEMS = 850;
  localparam int QUIET_TAIL = 120;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy;
  logic done;
  result_t result;

  AddressScoreboard board = new;

  cd_msf_lba_converter u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .cmd(cmd),
    .done(done),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (done === 1'b1) board.check_result(result);
    if (start && !busy) board.note_command(cmd);
  end

  function cmd_t junk_command();
    logic [63:0] junk;
    cmd_t c;
    junk = {$urandom, $urandom};
    c = junk[$bits(cmd_t)-1:0];
    return c;
  endfunction

  function logic [7:0] bcd_byte(int unsigned v);
    return 8'(((v / 10) << 4) | (v % 10));
  endfunction

  function cmd_t msf_command(logic bcd, logic [7:0] m, logic [7:0] s, logic [7:0] f);
    cmd_t c;
    c = junk_command();
    c.op = OP_MSF_TO_LBA;
    c.bcd = bcd;
    c.minute_in = m;
    c.second_in = s;
    c.frame_in = f;
    return c;
  endfunction

  function cmd_t lba_command(logic bcd, int addr);
    cmd_t c;
    c = junk_command();
    c.op = OP_LBA_TO_MSF;
    c.bcd = bcd;
    c.lba_in = addr[19:0];
    return c;
  endfunction

  function cmd_t random_command();
    cmd_t c;
    int unsigned m, s, f;
    int addr;
    c = junk_command();
    c.op = 1'($urandom_range(1));
    c.bcd = 1'($urandom_range(1));
    if (c.op == OP_MSF_TO_LBA) begin
      if ($urandom_range(9) < 7) begin
        m = $urandom_range(99);
        s = $urandom_range(59);
        f = $urandom_range(74);
        c.minute_in = c.bcd ? bcd_byte(m) : m[7:0];
        c.second_in = c.bcd ? bcd_byte(s) : s[7:0];
        c.frame_in = c.bcd ? bcd_byte(f) : f[7:0];
      end
    end else begin
      if ($urandom_range(9) < 6) addr = int'($urandom_range(899999)) - 450150;
      else addr = $urandom;
      c.lba_in = addr[19:0];
    end
    return c;
  endfunction

  task automatic send_command(cmd_t c);
    start <= 1'b1;
    cmd <= c;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(int n);
    start <= 1'b0;
    cmd <= junk_command();
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk); while (board.outstanding() != 0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_command(msf_command(1'b0, 8'd0, 8'd0, 8'd0));
    send_command(msf_command(1'b0, 8'd0, 8'd2, 8'd0));
    send_command(msf_command(1'b0, 8'd89, 8'd59, 8'd74));
    send_command(msf_command(1'b0, 8'd90, 8'd0, 8'd0));
    send_command(msf_command(1'b0, 8'd99, 8'd59, 8'd74));
    send_command(msf_command(1'b0, 8'd100, 8'd0, 8'd0));
    send_command(msf_command(1'b0, 8'd0, 8'd60, 8'd0));
    send_command(msf_command(1'b0, 8'd0, 8'd0, 8'd75));
    send_command(msf_command(1'b0, 8'hFF, 8'hFF, 8'hFF));
    idle_cycles(3);
    send_command(msf_command(1'b1, 8'h00, 8'h02, 8'h00));
    send_command(msf_command(1'b1, 8'h89, 8'h59, 8'h74));
    send_command(msf_command(1'b1, 8'h90, 8'h00, 8'h00));
    send_command(msf_command(1'b1, 8'h99, 8'h59, 8'h74));
    send_command(msf_command(1'b1, 8'hFF, 8'hFF, 8'hFF));
    send_command(msf_command(1'b1, 8'hAB, 8'h6C, 8'h7F));
    send_command(lba_command(1'b0, -150));
    send_command(lba_command(1'b0, -151));
    send_command(lba_command(1'b1, 0));
    send_command(lba_command(1'b0, -450150));
    send_command(lba_command(1'b1, -450151));
    send_command(lba_command(1'b0, -524288));
    send_command(lba_command(1'b1, 524287));
    send_command(lba_command(1'b1, 449849));
    send_command(lba_command(1'b0, 449850));
    send_command(lba_command(1'b1, -1));
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) wait_drained();
      if (i < RANDOM_ITEMS - QUIET_TAIL && $urandom_range(3) == 0)
        idle_cycles($urandom_range(18, 1));
      send_command(random_command());
    end

    wait_drained();
    repeat (12) @(posedge clk);
    board.final_check();
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
